// ===== sv/hkv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkv_pkg
// Codes, field widths and stream packing for the hashed key-value table.
// ----------------------------------------------------------------------------
package hkv_pkg;

  localparam int unsigned KIND_W   = 2;
  localparam int unsigned KEY_W    = 20;
  localparam int unsigned VALUE_W  = 64;
  localparam int unsigned STATUS_W = 2;

  // slave tdata: key, value, padded to whole bytes
  localparam int unsigned IN_TDATA_W  = ((KEY_W + VALUE_W + 7) / 8) * 8;
  // master tdata: status, found_value, padded to whole bytes
  localparam int unsigned OUT_TDATA_W = ((STATUS_W + VALUE_W + 7) / 8) * 8;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd2;

endpackage

// ===== sv/hashed_key_value_table_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hashed_key_value_table_top
// Key-value table of CAPACITY slots searched by key, one slot per cycle.
//
//   channel  dir  tdata (low bit up)               tuser
//   s_axis   in   key[19:0], value[83:20], pad     kind[1:0]
//   m_axis   out  status[1:0], found_value[65:2]   -
//
// The key memory is read one slot per cycle through its single registered
// read port and compared; the scan stops at the first hit, then the ACT
// state updates the store. Inserts into a full table and unused kinds answer
// in the cycle after the accept. The input is ready again in the cycle after
// the result beat is taken; a stalled result holds. Reset empties the table
// through the valid bits.
// ----------------------------------------------------------------------------
module hashed_key_value_table_top #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // key[19:0], value[83:20], zero pad
  input  logic [hkv_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // kind[1:0]
  input  logic [hkv_pkg::KIND_W-1:0]       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // status[1:0], found_value[65:2], zero pad
  output logic [hkv_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
  import hkv_pkg::*;

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_ACT  = 4'b0100,
    ST_RESP = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [KEY_W-1:0]    key_mem   [CAPACITY];
  logic [VALUE_W-1:0]  value_mem [CAPACITY];

  logic [CAPACITY-1:0] valid_q, valid_d;
  logic [CNT_W-1:0]    total_q, total_d;

  logic [KIND_W-1:0]   kind_q;
  logic [KEY_W-1:0]    key_q;
  logic [VALUE_W-1:0]  value_q;

  logic [CNT_W-1:0]    scan_q, scan_d;      // next slot to read
  logic                iss_q, iss_d;        // a slot read is in flight
  logic                iss_vld_q, iss_vld_d;
  logic [IDX_W-1:0]    iss_idx_q, iss_idx_d;
  logic [KEY_W-1:0]    rd_key_q;
  logic                hit_q, hit_d;
  logic [IDX_W-1:0]    hit_idx_q, hit_idx_d;
  logic                free_q, free_d;
  logic [IDX_W-1:0]    free_idx_q, free_idx_d;
  logic [VALUE_W-1:0]  rd_value_q;

  logic [STATUS_W-1:0] status_q, status_d;
  logic                sel_q, sel_d;        // found_value comes from the store

  logic                key_we, value_we;
  logic [IDX_W-1:0]    wr_idx;
  logic                cmp_hit;
  logic [IDX_W-1:0]    scan_idx;

  assign scan_idx = scan_q[IDX_W-1:0];
  assign cmp_hit  = iss_q && iss_vld_q && (rd_key_q == key_q);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = (state_q == ST_RESP);
  assign m_axis_tdata  = {{(OUT_TDATA_W - STATUS_W - VALUE_W){1'b0}},
                          (sel_q ? rd_value_q : {VALUE_W{1'b0}}), status_q};

  always_comb begin
    state_d    = state_q;
    valid_d    = valid_q;
    total_d    = total_q;
    scan_d     = scan_q;
    iss_d      = 1'b0;
    iss_vld_d  = iss_vld_q;
    iss_idx_d  = iss_idx_q;
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    status_d   = status_q;
    sel_d      = sel_q;
    key_we     = 1'b0;
    value_we   = 1'b0;
    wr_idx     = hit_idx_q;

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          scan_d   = '0;
          hit_d    = 1'b0;
          free_d   = 1'b0;
          status_d = STATUS_OK;
          sel_d    = 1'b0;
          if (s_axis_tuser == KIND_INSERT && total_q >= CAP_CNT) begin
            status_d = STATUS_FULL;
            state_d  = ST_RESP;
          end else if (s_axis_tuser inside {KIND_INSERT, KIND_LOOKUP, KIND_DELETE}) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_RESP;
          end
        end
      end

      ST_SCAN: begin
        if (cmp_hit) begin
          hit_d     = 1'b1;
          hit_idx_d = iss_idx_q;
          state_d   = ST_ACT;
        end else if (scan_q == CAP_CNT) begin
          state_d = ST_ACT;
        end else begin
          // issue read of the next slot, note the lowest free one on the way
          iss_d     = 1'b1;
          iss_vld_d = valid_q[scan_idx];
          iss_idx_d = scan_idx;
          if (!valid_q[scan_idx] && !free_q) begin
            free_d     = 1'b1;
            free_idx_d = scan_idx;
          end
          scan_d = scan_q + CNT_W'(1);
        end
      end

      ST_ACT: begin
        state_d = ST_RESP;
        case (kind_q)
          KIND_INSERT: begin
            if (hit_q) begin
              value_we = 1'b1;
            end else if (free_q) begin
              wr_idx            = free_idx_q;
              key_we            = 1'b1;
              value_we          = 1'b1;
              valid_d[free_idx_q] = 1'b1;
              total_d           = total_q + CNT_W'(1);
            end else begin
              status_d = STATUS_FULL;
            end
          end
          KIND_LOOKUP: begin
            if (hit_q) begin
              sel_d = 1'b1;
            end else begin
              status_d = STATUS_MISS;
            end
          end
          KIND_DELETE: begin
            if (hit_q) begin
              valid_d[hit_idx_q] = 1'b0;
              if (total_q != '0) begin
                total_d = total_q - CNT_W'(1);
              end
            end else begin
              status_d = STATUS_MISS;
            end
          end
          default: begin
          end
        endcase
      end

      ST_RESP: begin
        if (m_axis_tready) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= '0;
      total_q <= '0;
      iss_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      total_q <= total_d;
      iss_q   <= iss_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      kind_q  <= s_axis_tuser;
      key_q   <= s_axis_tdata[KEY_W-1:0];
      value_q <= s_axis_tdata[KEY_W+VALUE_W-1:KEY_W];
    end
    scan_q     <= scan_d;
    iss_vld_q  <= iss_vld_d;
    iss_idx_q  <= iss_idx_d;
    hit_q      <= hit_d;
    hit_idx_q  <= hit_idx_d;
    free_q     <= free_d;
    free_idx_q <= free_idx_d;
    status_q   <= status_d;
    sel_q      <= sel_d;
  end

  // slot store, one write and one registered read per memory
  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[wr_idx] <= key_q;
    end
    rd_key_q <= key_mem[scan_idx];
  end

  always_ff @(posedge clk_i) begin
    if (value_we) begin
      value_mem[wr_idx] <= value_q;
    end
    if (state_q == ST_ACT) begin
      rd_value_q <= value_mem[hit_idx_q];
    end
  end

endmodule

// ===== verif/hashed_key_value_table_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hashed_key_value_table_top_test
// Sends directed and random insert, lookup, delete and unused-kind beats into
// the key-value table and checks each result beat against a behavioral store copy.
// ----------------------------------------------------------------------------
module hashed_key_value_table_top_test;
  import hkv_pkg::*;

  localparam int unsigned SLOTS        = 32;
  localparam int unsigned BUCKET_COUNT = 32;
  localparam int unsigned KEY_TOP      = 999999;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam logic [KEY_W-1:0]  KEY_MAX     = 20'd999999;
  localparam int unsigned LIMIT_CYCLES = 1000000;
  localparam int unsigned DRAIN_CYCLES = 2 * SLOTS + 16;
  localparam int unsigned HOLDOFF_CYCLES = 400;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  found_value;
  } answer_t;

  class kv_scoreboard;
    bit                 slot_used  [SLOTS];
    logic [KEY_W-1:0]   slot_key   [SLOTS];
    logic [VALUE_W-1:0] slot_value [SLOTS];
    int unsigned        used_total;
    answer_t            awaited [$];
    int unsigned        mismatches;

    function int find_key(logic [KEY_W-1:0] key);
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_used[i] && slot_key[i] == key) return i;
      end
      return -1;
    endfunction

    // runs the operation on the local copy and queues its answer
    function void note_request(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] key,
                               logic [VALUE_W-1:0] value);
      answer_t ans;
      int      hit;
      int      spare;
      ans.status      = STATUS_OK;
      ans.found_value = '0;
      hit             = find_key(key);
      case (kind)
        KIND_INSERT: begin
          // full wins even over an update of a present key
          if (used_total >= SLOTS) begin
            ans.status = STATUS_FULL;
          end else if (hit >= 0) begin
            slot_value[hit] = value;
          end else begin
            spare = -1;
            for (int i = SLOTS - 1; i >= 0; i--) begin
              if (!slot_used[i]) spare = i;
            end
            slot_used[spare]  = 1'b1;
            slot_key[spare]   = key;
            slot_value[spare] = value;
            used_total++;
          end
        end
        KIND_LOOKUP: begin
          if (hit >= 0) ans.found_value = slot_value[hit];
          else ans.status = STATUS_MISS;
        end
        KIND_DELETE: begin
          if (hit >= 0) begin
            slot_used[hit] = 1'b0;
            used_total--;
          end else begin
            ans.status = STATUS_MISS;
          end
        end
        default: ;
      endcase
      awaited = {awaited, ans};
    endfunction

    task flag_mismatch(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task check_result(logic [OUT_TDATA_W-1:0] beat);
      answer_t             want;
      logic [STATUS_W-1:0] got_status;
      logic [VALUE_W-1:0]  got_value;
      got_status = beat[STATUS_W-1:0];
      got_value  = beat[STATUS_W +: VALUE_W];
      if (awaited.size() == 0) begin
        flag_mismatch($sformatf("unexpected result beat, status %0d value %h",
                                got_status, got_value));
        return;
      end
      want = awaited.pop_front();
      if (got_status !== want.status)
        flag_mismatch($sformatf("status %0d, want %0d", got_status, want.status));
      if (got_value !== want.found_value)
        flag_mismatch($sformatf("found_value %h, want %h", got_value, want.found_value));
    endtask

    task check_drained();
      if (awaited.size() != 0)
        flag_mismatch($sformatf("%0d results never arrived", awaited.size()));
    endtask
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic [KIND_W-1:0]      s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  kv_scoreboard store_model;
  int unsigned  send_idle_pct;
  int unsigned  recv_idle_pct;
  bit           holdoff_request;
  int unsigned  cycle_count;

  hashed_key_value_table_top #(
    .CAPACITY(SLOTS)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : result_sink
    int unsigned holdoff_left;
    bit          holdoff_taken;
    holdoff_left  = 0;
    holdoff_taken = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (holdoff_request && !holdoff_taken) begin
        holdoff_taken = 1'b1;
        holdoff_left  = HOLDOFF_CYCLES;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin : result_monitor
    forever begin
      @(posedge clk_i);
      if (rst_ni) begin
        if ($isunknown(m_axis_tvalid))
          store_model.flag_mismatch("m_axis_tvalid unknown");
        else if (m_axis_tvalid && m_axis_tready)
          store_model.check_result(m_axis_tdata);
      end
    end
  end

  // called at a falling edge, returns at the falling edge after the beat
  task automatic send_op(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key,
                         input logic [VALUE_W-1:0] value);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= IN_TDATA_W'({value, key});
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    store_model.note_request(kind, key, value);
    @(negedge clk_i);
  endtask

  // each segment draws on its own key pool and operation mix so that keys repeat,
  // chains form in one bucket, and insert-heavy stretches fill the table
  task automatic run_random(input int unsigned count);
    logic [KEY_W-1:0]   pool [64];
    logic [KEY_W-1:0]   key;
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] value;
    int unsigned        pool_n;
    int unsigned        bucket;
    int unsigned        roll;
    int unsigned        sent;
    int unsigned        ins_cut;
    int unsigned        look_cut;
    int unsigned        del_cut;
    sent = 0;
    while (sent < count) begin
      case ($urandom_range(3))
        0: pool_n = 6;
        1: pool_n = 24;
        2: pool_n = 40;
        default: pool_n = 64;
      endcase
      case ($urandom_range(2))
        0: begin ins_cut = 85; look_cut = 93; del_cut = 98; end
        1: begin ins_cut = 15; look_cut = 40; del_cut = 97; end
        default: begin ins_cut = 35; look_cut = 68; del_cut = 96; end
      endcase
      bucket = $urandom_range(BUCKET_COUNT - 1);
      for (int i = 0; i < pool_n; i++) begin
        roll = $urandom_range(9);
        if (roll < 4)
          pool[i] = KEY_W'(bucket + BUCKET_COUNT * $urandom_range(KEY_TOP / BUCKET_COUNT - 1));
        else if (roll == 4)
          pool[i] = $urandom_range(1) ? KEY_MAX : '0;
        else
          pool[i] = KEY_W'($urandom_range(KEY_TOP));
      end
      for (int j = 0; j < 80 && sent < count; j++) begin
        roll = $urandom_range(99);
        if (roll < ins_cut) kind = KIND_INSERT;
        else if (roll < look_cut) kind = KIND_LOOKUP;
        else if (roll < del_cut) kind = KIND_DELETE;
        else kind = KIND_UNUSED;
        if ($urandom_range(9) == 0) key = KEY_W'($urandom_range(KEY_TOP));
        else key = pool[6'($urandom_range(pool_n - 1))];
        roll = $urandom_range(19);
        if (roll == 0) value = '0;
        else if (roll == 1) value = '1;
        else value = {$urandom, $urandom};
        send_op(kind, key, value);
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    int unsigned waited;
    store_model     = new();
    rst_ni          = 1'b0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    s_axis_tuser    = KIND_INSERT;
    send_idle_pct   = 15;
    recv_idle_pct   = 87;
    holdoff_request = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // empty table, extremes, overwrite, a two-entry chain, misses, an unused kind
    send_op(KIND_LOOKUP, '0, '0);
    send_op(KIND_DELETE, KEY_MAX, '1);
    send_op(KIND_INSERT, '0, '0);
    send_op(KIND_INSERT, KEY_MAX, '1);
    send_op(KIND_LOOKUP, '0, '1);
    send_op(KIND_LOOKUP, KEY_MAX, '0);
    send_op(KIND_INSERT, '0, 64'hA5A5_5A5A_F00D_0001);
    send_op(KIND_LOOKUP, '0, '0);
    send_op(KIND_INSERT, 20'd32, 64'h0123_4567_89AB_CDEF);
    send_op(KIND_INSERT, 20'd999967, 64'h8000_0000_0000_0001);
    send_op(KIND_DELETE, '0, '0);
    send_op(KIND_LOOKUP, 20'd32, '0);
    send_op(KIND_LOOKUP, '0, '0);
    send_op(KIND_DELETE, '0, '0);
    send_op(KIND_UNUSED, 20'd32, '1);
    send_op(KIND_LOOKUP, 20'd32, '0);
    send_op(KIND_LOOKUP, 20'd999967, '0);
    send_op(KIND_LOOKUP, KEY_MAX, '0);

    run_random(700);
    send_idle_pct = 87;
    recv_idle_pct = 15;
    run_random(650);
    send_idle_pct   = 0;
    recv_idle_pct   = 0;
    holdoff_request = 1'b1;
    run_random(650);
    s_axis_tvalid <= 1'b0;

    waited = 0;
    while (store_model.awaited.size() != 0 && waited < 20000) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    store_model.check_drained();
    if (store_model.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== hashed_key_value_table_top.f =====
sv/hkv_pkg.sv
sv/hashed_key_value_table_top.sv
verif/hashed_key_value_table_top_test.sv
